/* rtl/core/qafs_pkg.sv */
// ----------------------------------------------------------------------------
// qafs_pkg
// Shared widths, constants and types for the quadrilateral area pipeline.
// ----------------------------------------------------------------------------
package qafs_pkg;

  localparam int SIDE_BITS     = 12;
  localparam int COS_FRAC_BITS = 16;
  localparam int ANGLE_W       = 13;
  localparam int AREA_W        = 28;

  localparam int SUM_W   = SIDE_BITS + 2;
  localparam int MAG_W   = SIDE_BITS + 2;
  localparam int P16_W   = 4 * MAG_W + 4;
  localparam int M_W     = 4 * SIDE_BITS;
  localparam int C_W     = COS_FRAC_BITS + 1;
  localparam int MC_W    = M_W + C_W - (COS_FRAC_BITS - 8);
  localparam int ROOT_W  = P16_W / 2;
  localparam int N_TERMS = 10;
  localparam int DIV_S   = 34;

  localparam logic [ANGLE_W-1:0] FULL_TURN    = ANGLE_W'(5760);
  localparam logic [ANGLE_W-1:0] HALF_TURN    = ANGLE_W'(2880);
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = ANGLE_W'(1440);
  localparam logic [ANGLE_W-1:0] EIGHTH_TURN  = ANGLE_W'(720);

  // pi in Q40; w*pi/2880 is split as w*RAD_A + floor(w*RAD_B/2880)
  localparam logic [63:0] PI_Q40   = 64'h3243F6A8885;
  localparam logic [63:0] RAD_DEN  = 64'd2880;
  localparam logic [63:0] RAD_A    = PI_Q40 / RAD_DEN;
  localparam logic [63:0] RAD_B    = PI_Q40 % RAD_DEN;
  localparam logic [63:0] RAD_R    = (64'd1 << DIV_S) / RAD_DEN;

  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  typedef struct packed {
    logic [P16_W-1:0] p16;
    logic [M_W-1:0]   m;
    logic             pinv;
  } side_t;

endpackage

/* rtl/core/qafs_prod.sv */
// ----------------------------------------------------------------------------
// qafs_prod
// Side products: 16*(S-2a)(S-2b)(S-2c)(S-2d), a*b*c*d and the sign of P.
// ----------------------------------------------------------------------------
module qafs_prod (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  input  logic [qafs_pkg::SIDE_BITS-1:0]   in_a,
  input  logic [qafs_pkg::SIDE_BITS-1:0]   in_b,
  input  logic [qafs_pkg::SIDE_BITS-1:0]   in_c,
  input  logic [qafs_pkg::SIDE_BITS-1:0]   in_d,
  input  logic [qafs_pkg::ANGLE_W-1:0]     in_ang,
  output logic                             out_vld,
  output logic [qafs_pkg::ANGLE_W-1:0]     out_ang,
  output qafs_pkg::side_t                  out_side
);
  import qafs_pkg::*;

  localparam int AB_W = 2 * SIDE_BITS;
  localparam int MP_W = 2 * MAG_W;
  localparam int P_W  = 4 * MAG_W;

  logic [2:0]             vld_r;
  logic [SIDE_BITS-1:0]   s1_s_r [4];
  logic [SUM_W-1:0]       s1_sum_r;
  logic [ANGLE_W-1:0]     s1_ang_r, s2_ang_r, s3_ang_r, s4_ang_r;

  logic [MAG_W-1:0]       s2_mag_r [4];
  logic                   s2_par_r, s3_par_r;
  logic [AB_W-1:0]        s2_ab_r, s2_cd_r;
  logic [MP_W-1:0]        s3_m01_r, s3_m23_r;
  logic [M_W-1:0]         s3_m_r;
  side_t                  s4_side_r;
  logic                   s4_vld_r;

  logic [MAG_W-1:0]       mag_nxt [4];
  logic [3:0]             neg_nxt;
  logic [P_W-1:0]         p_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [SUM_W-1:0] dbl;
      dbl = {1'b0, s1_s_r[i], 1'b0};
      neg_nxt[i] = dbl > s1_sum_r;
      mag_nxt[i] = neg_nxt[i] ? MAG_W'(dbl - s1_sum_r) : MAG_W'(s1_sum_r - dbl);
    end
  end

  assign p_nxt = P_W'(s3_m01_r) * P_W'(s3_m23_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      s4_vld_r <= 1'b0;
    end else begin
      vld_r    <= {vld_r[1:0], in_vld};
      s4_vld_r <= vld_r[2];
    end
  end

  always_ff @(posedge clk) begin
    s1_s_r[0] <= in_a;
    s1_s_r[1] <= in_b;
    s1_s_r[2] <= in_c;
    s1_s_r[3] <= in_d;
    s1_sum_r  <= SUM_W'(in_a) + SUM_W'(in_b) + SUM_W'(in_c) + SUM_W'(in_d);
    s1_ang_r  <= in_ang;

    s2_mag_r  <= mag_nxt;
    s2_par_r  <= ^neg_nxt;
    s2_ab_r   <= AB_W'(s1_s_r[0]) * AB_W'(s1_s_r[1]);
    s2_cd_r   <= AB_W'(s1_s_r[2]) * AB_W'(s1_s_r[3]);
    s2_ang_r  <= s1_ang_r;

    s3_m01_r  <= MP_W'(s2_mag_r[0]) * MP_W'(s2_mag_r[1]);
    s3_m23_r  <= MP_W'(s2_mag_r[2]) * MP_W'(s2_mag_r[3]);
    s3_m_r    <= M_W'(s2_ab_r) * M_W'(s2_cd_r);
    s3_par_r  <= s2_par_r;
    s3_ang_r  <= s2_ang_r;

    s4_side_r.p16  <= {p_nxt, 4'b0000};
    s4_side_r.m    <= s3_m_r;
    s4_side_r.pinv <= s3_par_r && (p_nxt != '0);
    s4_ang_r       <= s3_ang_r;
  end

  assign out_vld  = s4_vld_r;
  assign out_ang  = s4_ang_r;
  assign out_side = s4_side_r;

endmodule

/* rtl/core/qafs_cos.sv */
// ----------------------------------------------------------------------------
// qafs_cos
// Fixed-point (1+cos)/2 of the angle sum: fold, radians, Taylor series with
// one term per four stages; the side products ride along unchanged.
// ----------------------------------------------------------------------------
module qafs_cos (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [qafs_pkg::ANGLE_W-1:0]  in_ang,
  input  qafs_pkg::side_t               in_side,
  output logic                          out_vld,
  output logic [qafs_pkg::C_W-1:0]      out_c,
  output qafs_pkg::side_t               out_side
);
  import qafs_pkg::*;

  localparam int NS    = 4 * N_TERMS;
  localparam int W_W   = 10;
  localparam int WA_W  = 42;
  localparam int WB_W  = 22;
  localparam int QB_W  = 11;
  localparam int CN_W  = 34 + COS_FRAC_BITS + 1;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  typedef struct packed {
    logic               neg;
    logic               odd;
    logic [31:0]        x;
    logic [32:0]        tv;
    logic [32:0]        q0;
    logic signed [34:0] sum;
    side_t              side;
  } ser_t;

  function automatic logic [32:0] qmul(logic [32:0] a, logic [31:0] b);
    logic [64:0] pr;
    pr = 65'(a) * 65'(b) + 65'(33'h0_8000_0000);
    return pr[64:32];
  endfunction

  // front end
  logic                 vf_r, vw_r, vq_r;
  logic                 f_neg_r, w_neg_r, q_neg_r;
  logic                 f_odd_r, w_odd_r, q_odd_r;
  logic [W_W-1:0]       f_w_r;
  logic [WA_W-1:0]      w_wa_r, q_wa_r;
  logic [WB_W-1:0]      w_wb_r, q_wb_r;
  logic [QB_W-1:0]      q_qb0_r;
  side_t                f_side_r, w_side_r, q_side_r;

  logic [ANGLE_W-1:0]   t0, t1, t2, wv;
  logic                 neg_nxt, odd_nxt;
  logic [WB_W+23:0]     qb_pr;
  logic [WB_W-1:0]      qb_rem;
  logic [QB_W-1:0]      qb;
  logic [WA_W-1:0]      xs;

  always_comb begin
    t0      = (in_ang >= FULL_TURN) ? in_ang - FULL_TURN : in_ang;
    t1      = (t0 > HALF_TURN) ? FULL_TURN - t0 : t0;
    neg_nxt = t1 > QUARTER_TURN;
    t2      = neg_nxt ? HALF_TURN - t1 : t1;
    odd_nxt = t2 > EIGHTH_TURN;
    wv      = odd_nxt ? QUARTER_TURN - t2 : t2;
  end

  assign qb_pr  = (WB_W + 24)'(w_wb_r) * (WB_W + 24)'(RAD_R[23:0]);
  assign qb_rem = q_wb_r - WB_W'(q_qb0_r) * WB_W'(RAD_DEN[11:0]);
  assign qb     = (qb_rem >= WB_W'(RAD_DEN)) ? q_qb0_r + QB_W'(1) : q_qb0_r;
  assign xs     = q_wa_r + WA_W'(qb) + WA_W'(128);

  // series stages
  ser_t          st_r [0:NS];
  logic [NS:0]   vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r  <= 1'b0;
      vw_r  <= 1'b0;
      vq_r  <= 1'b0;
      vld_r <= '0;
    end else begin
      vf_r  <= in_vld;
      vw_r  <= vf_r;
      vq_r  <= vw_r;
      vld_r <= {vld_r[NS-1:0], vq_r};
    end
  end

  always_ff @(posedge clk) begin
    f_neg_r  <= neg_nxt;
    f_odd_r  <= odd_nxt;
    f_w_r    <= W_W'(wv);
    f_side_r <= in_side;

    w_neg_r  <= f_neg_r;
    w_odd_r  <= f_odd_r;
    w_wa_r   <= WA_W'(f_w_r) * WA_W'(RAD_A[31:0]);
    w_wb_r   <= WB_W'(f_w_r) * WB_W'(RAD_B[11:0]);
    w_side_r <= f_side_r;

    q_neg_r  <= w_neg_r;
    q_odd_r  <= w_odd_r;
    q_wa_r   <= w_wa_r;
    q_wb_r   <= w_wb_r;
    q_qb0_r  <= QB_W'(qb_pr[DIV_S +: QB_W]);
    q_side_r <= w_side_r;

    st_r[0].neg  <= q_neg_r;
    st_r[0].odd  <= q_odd_r;
    st_r[0].x    <= xs[39:8];
    st_r[0].tv   <= q_odd_r ? {1'b0, xs[39:8]} : ONE_Q32;
    st_r[0].q0   <= '0;
    st_r[0].sum  <= q_odd_r ? 35'(signed'({3'b000, xs[39:8]})) : 35'(signed'({2'b00, ONE_Q32}));
    st_r[0].side <= q_side_r;
  end

  for (genvar k = 0; k < N_TERMS; k++) begin : g_term
    localparam int unsigned DEN_E = (2 * k + 1) * (2 * k + 2);
    localparam int unsigned DEN_O = (2 * k + 2) * (2 * k + 3);
    localparam logic [DIV_S-1:0] RCP_E = DIV_S'((64'd1 << DIV_S) / DEN_E);
    localparam logic [DIV_S-1:0] RCP_O = DIV_S'((64'd1 << DIV_S) / DEN_O);
    localparam bit ADD_TERM = (k % 2) == 1;
    localparam int PW = 33 + DIV_S;

    logic [PW-1:0] pr;
    logic [8:0]    den;
    logic [32:0]   rem, qk;

    assign pr  = PW'(st_r[4*k+2].tv) * PW'(st_r[4*k+2].odd ? RCP_O : RCP_E);
    assign den = st_r[4*k+3].odd ? 9'(DEN_O) : 9'(DEN_E);
    assign rem = st_r[4*k+3].tv - 33'(st_r[4*k+3].q0 * 33'(den));
    assign qk  = (rem >= 33'(den)) ? st_r[4*k+3].q0 + 33'd1 : st_r[4*k+3].q0;

    always_ff @(posedge clk) begin
      ser_t st1_nxt, st2_nxt, st3_nxt, st4_nxt;
      st1_nxt    = st_r[4*k];
      st1_nxt.tv = qmul(st_r[4*k].tv, st_r[4*k].x);

      st2_nxt    = st_r[4*k+1];
      st2_nxt.tv = qmul(st_r[4*k+1].tv, st_r[4*k+1].x);

      st3_nxt    = st_r[4*k+2];
      st3_nxt.q0 = pr[PW-1:DIV_S];

      st4_nxt    = st_r[4*k+3];
      st4_nxt.tv = qk;
      if (ADD_TERM) begin
        st4_nxt.sum = st_r[4*k+3].sum + 35'(signed'({2'b00, qk}));
      end else begin
        st4_nxt.sum = st_r[4*k+3].sum - 35'(signed'({2'b00, qk}));
      end

      st_r[4*k+1] <= st1_nxt;
      st_r[4*k+2] <= st2_nxt;
      st_r[4*k+3] <= st3_nxt;
      st_r[4*k+4] <= st4_nxt;
    end
  end

  // clamp, form 1+cos, round to C_W bits
  logic [32:0]     v;
  logic [33:0]     n;
  logic [CN_W-1:0] cw;
  logic            vo_r;
  logic [C_W-1:0]  c_r;
  side_t           side_r;

  always_comb begin
    priority if (st_r[NS].sum < 0) begin
      v = '0;
    end else if (st_r[NS].sum > 35'(signed'({2'b00, ONE_Q32}))) begin
      v = ONE_Q32;
    end else begin
      v = st_r[NS].sum[32:0];
    end
    n  = st_r[NS].neg ? 34'(ONE_Q32) - 34'(v) : 34'(ONE_Q32) + 34'(v);
    cw = (CN_W'(n) << COS_FRAC_BITS) + (CN_W'(1) << 32);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    c_r    <= cw[33 +: C_W];
    side_r <= st_r[NS].side;
  end

  assign out_vld  = vo_r;
  assign out_c    = c_r;
  assign out_side = side_r;

  a_c_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> out_c <= (C_W'(1) << COS_FRAC_BITS))
    else $error("cos weight above one");

endmodule

/* rtl/core/qafs_root.sv */
// ----------------------------------------------------------------------------
// qafs_root
// Radicand 16*P - M*C/256, validity check and a bit-per-stage square root.
// ----------------------------------------------------------------------------
module qafs_root (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [qafs_pkg::C_W-1:0]      in_c,
  input  qafs_pkg::side_t               in_side,
  output logic                          out_vld,
  output logic [qafs_pkg::AREA_W-1:0]   out_area,
  output logic                          out_invalid
);
  import qafs_pkg::*;

  localparam int MCP_W = M_W + C_W;
  localparam int CMP_W = (MC_W > P16_W) ? MC_W : P16_W;
  localparam int RM_W  = ROOT_W + 4;

  typedef struct packed {
    logic [RM_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
    logic [P16_W-1:0]  rad;
    logic              inv;
  } sq_t;

  logic             v1_r, v2_r;
  logic [MC_W-1:0]  s1_mc_r;
  logic [P16_W-1:0] s1_p16_r;
  logic             s1_pinv_r;
  logic [MCP_W-1:0] mcp;
  logic             inv_nxt;
  logic [CMP_W-1:0] diff;

  assign mcp     = MCP_W'(in_side.m) * MCP_W'(in_c);
  assign inv_nxt = s1_pinv_r || (CMP_W'(s1_mc_r) > CMP_W'(s1_p16_r));
  assign diff    = CMP_W'(s1_p16_r) - CMP_W'(s1_mc_r);

  sq_t              sq_r [0:ROOT_W];
  logic [ROOT_W:0]  sv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      sv_r <= '0;
    end else begin
      v1_r <= in_vld;
      sv_r <= {sv_r[ROOT_W-1:0], v1_r};
    end
  end

  always_ff @(posedge clk) begin
    s1_mc_r   <= MC_W'(mcp >> (COS_FRAC_BITS - 8));
    s1_p16_r  <= in_side.p16;
    s1_pinv_r <= in_side.pinv;

    sq_r[0].rem  <= '0;
    sq_r[0].root <= '0;
    sq_r[0].rad  <= inv_nxt ? '0 : P16_W'(diff);
    sq_r[0].inv  <= inv_nxt;
  end

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    logic [RM_W-1:0] cur, trial;

    assign cur   = {sq_r[i].rem[RM_W-3:0], sq_r[i].rad[P16_W-1 -: 2]};
    assign trial = RM_W'({sq_r[i].root, 2'b01});

    always_ff @(posedge clk) begin
      sq_r[i+1].rad <= sq_r[i].rad << 2;
      sq_r[i+1].inv <= sq_r[i].inv;
      if (cur >= trial) begin
        sq_r[i+1].rem  <= cur - trial;
        sq_r[i+1].root <= {sq_r[i].root[ROOT_W-2:0], 1'b1};
      end else begin
        sq_r[i+1].rem  <= cur;
        sq_r[i+1].root <= {sq_r[i].root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  logic              vo_r;
  logic [AREA_W-1:0] area_r;
  logic              inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= sv_r[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    area_r <= (sq_r[ROOT_W].root > ROOT_W'(AREA_MAX)) ? AREA_MAX
                                                      : AREA_W'(sq_r[ROOT_W].root);
    inv_r  <= sq_r[ROOT_W].inv;
  end

  assign v2_r        = sv_r[0];
  assign out_vld     = vo_r;
  assign out_area    = area_r;
  assign out_invalid = inv_r;

  // a finished root leaves a remainder of at most twice the root
  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r[ROOT_W] |-> sq_r[ROOT_W].rem <= RM_W'({sq_r[ROOT_W].root, 1'b0}))
    else $error("square root remainder out of range");

  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_invalid |-> out_area == '0)
    else $error("invalid beat carries nonzero area");

  a_inv_rad: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && sq_r[0].inv |=> sq_r[1].root == '0)
    else $error("invalid item entered root with nonzero radicand");

endmodule

/* rtl/core/quadrilateral_area_from_sides_top.sv */
// ----------------------------------------------------------------------------
// quadrilateral_area_from_sides_top
// Bretschneider area from four sides and an opposite-angle sum.
// ----------------------------------------------------------------------------
// A new item may be started on every clock; busy is never raised. Each item
// yields exactly one result beat: out_strobe is raised for it once the item
// has passed the product, cosine and square-root stages, in order. Most of
// the pipeline depth lies in the cosine series (four stages per term, ten
// terms) and the 30-stage square root. There is no backpressure on the
// result side, so a beat must be taken when shown.
// ----------------------------------------------------------------------------
module quadrilateral_area_from_sides_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [qafs_pkg::SIDE_BITS-1:0]    in_side_a,
  input  logic [qafs_pkg::SIDE_BITS-1:0]    in_side_b,
  input  logic [qafs_pkg::SIDE_BITS-1:0]    in_side_c,
  input  logic [qafs_pkg::SIDE_BITS-1:0]    in_side_d,
  input  logic [qafs_pkg::ANGLE_W-1:0]      in_angle_sum,
  output logic                              out_strobe,
  output logic [qafs_pkg::AREA_W-1:0]       out_area,
  output logic                              out_invalid
);
  import qafs_pkg::*;

  logic               acc;
  logic               pv;
  logic [ANGLE_W-1:0] pang;
  side_t              pside;
  logic               cv;
  logic [C_W-1:0]     cc;
  side_t              cside;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  qafs_prod u_prod (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (acc),
    .in_a     (in_side_a),
    .in_b     (in_side_b),
    .in_c     (in_side_c),
    .in_d     (in_side_d),
    .in_ang   (in_angle_sum),
    .out_vld  (pv),
    .out_ang  (pang),
    .out_side (pside)
  );

  qafs_cos u_cos (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (pv),
    .in_ang   (pang),
    .in_side  (pside),
    .out_vld  (cv),
    .out_c    (cc),
    .out_side (cside)
  );

  qafs_root u_root (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (cv),
    .in_c        (cc),
    .in_side     (cside),
    .out_vld     (out_strobe),
    .out_area    (out_area),
    .out_invalid (out_invalid)
  );

endmodule
